// ===== design/cthr_pkg.sv =====
// ----------------------------------------------------------------------------
// cthr_pkg
// Shared types and constants for the current threshold relay hold unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cthr_pkg;

    localparam int TIME_W   = 32;   // millisecond clock
    localparam int HOLD_W   = 22;   // hold delay in ms
    localparam int CUR_W    = 16;   // current in 0.01 A
    localparam int STN_W    = 4;    // station field
    localparam int MASK_W   = 16;   // notify mask
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 22;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_ON_THRESHOLD = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_OFF_DELAY    = 1'd1;

    // per-station timing entry
    typedef struct packed {
        logic [TIME_W-1:0] change_time;
        logic [HOLD_W-1:0] hold_delay;
    } t_hold_entry;

    // write request into the hold store
    typedef struct packed {
        logic        en;
        t_hold_entry data;
    } t_hold_wr;

endpackage

`default_nettype wire

// ===== design/cthr_hold_ram.sv =====
// ----------------------------------------------------------------------------
// cthr_hold_ram
// Per-station change time / hold delay store with registered read. Valid
// bits stand in for the all-zero reset; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cthr_hold_ram #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  cthr_pkg::t_hold_wr          i_wr,
    input  wire  [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  wire                         i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]    i_rd_addr,
    output cthr_pkg::t_hold_entry       o_rd_data
);

    cthr_pkg::t_hold_entry r_mem [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    cthr_pkg::t_hold_entry r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== design/current_threshold_relay_hold_unit.sv =====
// ----------------------------------------------------------------------------
// current_threshold_relay_hold_unit
// Debounces per-station tool current against a threshold, holds the collector
// relay on for the off delay after a drop, and flags stations to notify.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: op; tdata: station,
//           |     |                               |   current_centiamps
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: relay_on, relay_changed,
//           |     |                               |   notify_mask
//  cfg      | in  | i_cfg_wr_en                   | i_cfg_addr, i_cfg_wdata
//
//  An item is handled in steps: the reading or tick is applied, then each
//  station in turn gets a read step and an evaluate step through the single
//  hold store port and the shared elapsed-time subtract/compare.
//  Reset is synchronous, active low; no clearing pass is needed.
//  The result sits in an output register; a new item is taken while it waits,
//  and only a second finished result stalls until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module current_threshold_relay_hold_unit #(
    parameter int STATIONS    = 16,
    parameter int DEBOUNCE_MS = 750
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input items
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [23:0]                    s_axis_tdata,  // [3:0] station, [19:4] current
    input  wire                            s_axis_tuser,  // [0] op (1 = tick)
    // result items
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [23:0]                    m_axis_tdata,  // [0] relay_on,
                                                          // [1] relay_changed,
                                                          // [17:2] notify_mask
    // configuration
    input  wire                            i_cfg_wr_en,
    input  wire  [cthr_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  wire  [cthr_pkg::CFG_D_W-1:0]   i_cfg_wdata
);

    localparam int AW = $clog2(STATIONS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic [cthr_pkg::CUR_W-1:0]        r_threshold;
    logic [cthr_pkg::HOLD_W-1:0]       r_off_delay;
    logic [cthr_pkg::TIME_W-1:0]       r_now;
    logic [STATIONS-1:0]               r_on;
    logic [STATIONS-1:0]               r_pend;
    logic                              r_relay;
    logic [AW-1:0]                     r_idx;
    logic                              r_active;
    logic [cthr_pkg::MASK_W-1:0]       r_changed;
    logic                              r_out_valid;
    logic                              r_out_on;
    logic                              r_out_chg;
    logic [cthr_pkg::MASK_W-1:0]       r_out_mask;

    // input decode
    logic                              in_acc;
    logic                              in_tick;
    logic [cthr_pkg::STN_W-1:0]        in_stn;
    logic [cthr_pkg::CUR_W-1:0]        in_cur;
    logic [AW-1:0]                     stn_idx;
    logic                              stn_ok;
    logic                              above;
    logic                              rd_take;
    logic                              rd_sched;

    cthr_pkg::t_hold_wr                hold_wr;
    cthr_pkg::t_hold_entry             rd_data;

    // shared evaluate unit
    logic [cthr_pkg::TIME_W-1:0]       elapsed;
    logic                              expired;
    logic                              commit;
    logic                              new_on;
    logic                              hold_off;
    logic                              out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_tick       = s_axis_tuser;
    assign in_stn        = s_axis_tdata[3:0];
    assign in_cur        = s_axis_tdata[19:4];
    assign stn_idx       = AW'(in_stn);
    assign stn_ok        = (32'(in_stn) < STATIONS);
    assign above         = (in_cur >= r_threshold);
    assign rd_take       = in_acc && !in_tick && stn_ok;
    // a new change is scheduled only when no change is pending
    assign rd_sched      = (above != r_on[stn_idx]) && (r_pend[stn_idx] == r_on[stn_idx]);

    always_comb begin
        hold_wr.en               = rd_take && rd_sched;
        hold_wr.data.change_time = r_now;
        hold_wr.data.hold_delay  = above ? cthr_pkg::HOLD_W'(DEBOUNCE_MS) : r_off_delay;
    end

    cthr_hold_ram #(
        .DEPTH (STATIONS)
    ) u_hold_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (hold_wr),
        .i_wr_addr (stn_idx),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign elapsed  = r_now - rd_data.change_time;
    assign expired  = (elapsed >= cthr_pkg::TIME_W'(rd_data.hold_delay));
    assign commit   = (r_pend[r_idx] != r_on[r_idx]) && expired;
    assign new_on   = commit ? r_pend[r_idx] : r_on[r_idx];
    assign hold_off = !r_pend[r_idx] && !expired;
    assign out_free = !r_out_valid || m_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cthr_pkg::CUR_W'(100);
            r_off_delay <= cthr_pkg::HOLD_W'(5000);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                cthr_pkg::REG_ON_THRESHOLD: r_threshold <= i_cfg_wdata[cthr_pkg::CUR_W-1:0];
                cthr_pkg::REG_OFF_DELAY:    r_off_delay <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_on        <= '0;
            r_pend      <= '0;
            r_relay     <= 1'b0;
            r_idx       <= '0;
            r_active    <= 1'b0;
            r_changed   <= '0;
            r_out_valid <= 1'b0;
            r_out_on    <= 1'b0;
            r_out_chg   <= 1'b0;
            r_out_mask  <= '0;
        end else begin
            // S_DONE handles the output register itself
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_tick) begin
                            r_now <= r_now + 1'b1;
                        end else if (stn_ok) begin
                            if (above == r_on[stn_idx]) begin
                                r_pend[stn_idx] <= r_on[stn_idx];
                            end else if (rd_sched) begin
                                r_pend[stn_idx] <= above;
                            end
                        end
                        r_idx     <= '0;
                        r_active  <= 1'b0;
                        r_changed <= '0;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_on[r_idx] <= new_on;
                    r_active    <= r_active || new_on || hold_off;
                    // stations above the mask width shift out
                    r_changed   <= r_changed | (cthr_pkg::MASK_W'(commit) << r_idx);
                    if (32'(r_idx) == STATIONS - 1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_relay     <= r_active;
                        r_out_valid <= 1'b1;
                        r_out_on    <= r_active;
                        r_out_chg   <= (r_active != r_relay);
                        r_out_mask  <= (r_active != r_relay) ? r_changed : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_mask, r_out_chg, r_out_on};

endmodule

`default_nettype wire
